### hw/rtl/tsc_pkg.sv
// Shared constants and types for the Taylor-series sine/cosine pipeline.
package tsc_pkg;

  localparam int unsigned MAX_TERMS = 32;

  localparam int unsigned ANG_W = 18;
  localparam int unsigned OUT_W = 32;
  localparam int unsigned THR_W = 31;
  localparam int unsigned X2_W  = 35;   // x^2 in Q28, below 2^35 for any 18-bit angle
  localparam int unsigned MAG_W = 51;   // term magnitude, capped at 2^50
  localparam int unsigned SUM_W = 57;   // 32 terms of at most 2^50 plus sign
  localparam int unsigned DIV_W = 15;   // (2k+2)(2k+3) up to MAX_TERMS = 32

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1074);
  localparam logic [MAG_W-1:0] TERM_CAP  = MAG_W'(1) << 50;
  localparam logic [MAG_W-1:0] COS_FIRST = MAG_W'(1) << 30;

  // radians = deg_q8 * 31415926 * 2^20 / 1.8e9, rounded
  // = floor((deg_q8 * 31415926 * 2^12 + DEG_HALF) / DEG_DEN)
  localparam logic [24:0] PI_SCALED = 25'd31415926;
  localparam logic [22:0] DEG_HALF  = 23'd3515625;
  localparam logic [22:0] DEG_DEN   = 23'd7031250;
  localparam logic [63:0] DEG_RCP64 = (64'd1 << 56) / 64'd7031250;
  localparam logic [33:0] DEG_RCP   = DEG_RCP64[33:0];

  // Control and running sums that travel with each transaction.
  // Lane 0 is sine, lane 1 is cosine.
  typedef struct packed {
    logic                  vld;
    logic                  sneg;
    logic [X2_W-1:0]       x2;
    logic [1:0]            done;
    logic [1:0][SUM_W-1:0] sum;
  } ctl_t;

endpackage

### hw/rtl/taylor_sine_cosine.sv
// Top level: fully pipelined Taylor-series sine and cosine of an angle in degrees.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  input    | angle_deg                               | start & !busy
//  result   | sine, cosine, not_converged             | valid, one cycle, no back-pressure
//  config   | stop_threshold                          | stop_threshold_wr
//
//  One transaction enters every cycle; busy stays low.
//  The front converts degrees to radians and forms x^2, then come term stages for
//  32 terms (two-part multiply by x^2, reciprocal divide, correction), then the output register.
//  Both series run in parallel lanes of the same term stages.
//  Reset clears the valid bits of every stage and loads the default threshold.
//  The result side cannot stall, so nothing in the pipeline ever holds.
module taylor_sine_cosine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [tsc_pkg::ANG_W-1:0] angle_deg,
  input  logic                         stop_threshold_wr,
  input  logic [tsc_pkg::THR_W-1:0]    stop_threshold,
  output logic                         valid,
  output logic signed [tsc_pkg::OUT_W-1:0] sine,
  output logic signed [tsc_pkg::OUT_W-1:0] cosine,
  output logic                         not_converged
);
  import tsc_pkg::*;

  localparam int unsigned LATENCY = 5 + 5 * MAX_TERMS + 1;

  logic [THR_W-1:0] thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (stop_threshold_wr) begin
      thr <= stop_threshold;
    end
  end

  assign busy = 1'b0;

  // ---------------- front: degrees to radians, x^2 ----------------
  logic [4:0]  fv;
  logic [4:0]  fneg;
  logic [42:0] f1_p;
  logic [54:0] f2_n;
  logic [61:0] f2_pa;
  logic [60:0] f2_pb;
  logic [54:0] f3_n;
  logic [31:0] f3_q;
  logic [31:0] f4_xm;
  logic [X2_W-1:0] f5_x2;
  logic [31:0] f5_xm;

  logic [ANG_W-1:0] amag;
  logic [54:0]      n2;
  logic [89:0]      f3_full;
  logic [55:0]      f4_r;
  logic [32:0]      f4_q;
  logic [63:0]      f5_sq;

  assign amag    = angle_deg[ANG_W-1] ? ANG_W'(-angle_deg) : ANG_W'(angle_deg);
  assign n2      = (55'(f1_p) << 12) + 55'(DEG_HALF);
  assign f3_full = 90'(f2_pa) + (90'(f2_pb) << 28);
  assign f4_r    = 56'(f3_n) - 56'(f3_q) * 56'(DEG_DEN);
  assign f4_q    = (f4_r >= 56'(DEG_DEN)) ? 33'(f3_q) + 33'd1 : 33'(f3_q);
  assign f5_sq   = 64'(f4_xm) * 64'(f4_xm);

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      fv <= {fv[3:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    fneg  <= {fneg[3:0], angle_deg[ANG_W-1]};
    f1_p  <= 43'(amag) * 43'(PI_SCALED);
    f2_n  <= n2;
    f2_pa <= 62'(n2[27:0]) * 62'(DEG_RCP);
    f2_pb <= 61'(n2[54:28]) * 61'(DEG_RCP);
    f3_n  <= f2_n;
    f3_q  <= f3_full[87:56];
    f4_xm <= f4_q[31:0];
    f5_x2 <= f5_sq[62:28];
    f5_xm <= f4_xm;
  end

  // ---------------- term stages ----------------
  wire ctl_t             tc [MAX_TERMS+1];
  wire [1:0][MAG_W-1:0]  tm [MAX_TERMS+1];

  assign tc[0] = '{vld: fv[4], sneg: fneg[4], x2: f5_x2, done: 2'b00, sum: '0};
  assign tm[0] = {COS_FIRST, MAG_W'(f5_xm) << 2};

  for (genvar k = 0; k < MAX_TERMS; k++) begin : g_term
    localparam bit K_ODD = (k % 2) == 1;

    ctl_t upd;
    ctl_t c1, c2, c3, c4, c5;
    logic s_neg;

    assign s_neg = tc[k].sneg ^ K_ODD;

    // Stop test and accumulate before this term's successor is formed.
    always_comb begin
      upd = tc[k];
      if (!tc[k].done[0]) begin
        if (tm[k][0] < MAG_W'(thr)) begin
          upd.done[0] = 1'b1;
        end else begin
          upd.sum[0] = s_neg ? tc[k].sum[0] - SUM_W'(tm[k][0])
                             : tc[k].sum[0] + SUM_W'(tm[k][0]);
        end
      end
      if (!tc[k].done[1]) begin
        if (tm[k][1] < MAG_W'(thr)) begin
          upd.done[1] = 1'b1;
        end else begin
          upd.sum[1] = K_ODD ? tc[k].sum[1] - SUM_W'(tm[k][1])
                             : tc[k].sum[1] + SUM_W'(tm[k][1]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        c1.vld <= 1'b0;
        c2.vld <= 1'b0;
        c3.vld <= 1'b0;
        c4.vld <= 1'b0;
        c5.vld <= 1'b0;
      end else begin
        c1.vld <= upd.vld;
        c2.vld <= c1.vld;
        c3.vld <= c2.vld;
        c4.vld <= c3.vld;
        c5.vld <= c4.vld;
      end
      c1.sneg <= upd.sneg;
      c1.x2   <= upd.x2;
      c1.done <= upd.done;
      c1.sum  <= upd.sum;
      c2.sneg <= c1.sneg;
      c2.x2   <= c1.x2;
      c2.done <= c1.done;
      c2.sum  <= c1.sum;
      c3.sneg <= c2.sneg;
      c3.x2   <= c2.x2;
      c3.done <= c2.done;
      c3.sum  <= c2.sum;
      c4.sneg <= c3.sneg;
      c4.x2   <= c3.x2;
      c4.done <= c3.done;
      c4.sum  <= c3.sum;
      c5.sneg <= c4.sneg;
      c5.x2   <= c4.x2;
      c5.done <= c4.done;
      c5.sum  <= c4.sum;
    end

    assign tc[k+1] = c5;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      localparam int unsigned DIV = (l == 0) ? (2*k + 2) * (2*k + 3)
                                             : (2*k + 1) * (2*k + 2);
      localparam logic [63:0]      RCP  = (64'd1 << 58) / 64'(DIV);
      localparam logic [DIV_W-1:0] DIVW = DIV_W'(DIV);

      logic [60:0]       plo;
      logic [59:0]       phi;
      logic [57:0]       sc2, sc3, sc4;
      logic [57:0]       pp0, pp1, pp2, pp3;
      logic [56:0]       q4;
      logic [MAG_W-1:0]  mag5;

      logic [85:0]  prod;
      logic [116:0] full;
      logic [71:0]  rem;
      logic [57:0]  q5;

      assign prod = 86'(plo) + (86'(phi) << 26);
      assign full = 117'(pp0) + ((117'(pp1) + 117'(pp2)) << 29) + (117'(pp3) << 58);
      assign rem  = 72'(sc4) - 72'(q4) * 72'(DIVW);
      assign q5   = (rem >= 72'(DIVW)) ? 58'(q4) + 58'd1 : 58'(q4);

      always_ff @(posedge clk) begin
        plo  <= 61'(tm[k][l][25:0]) * 61'(upd.x2);
        phi  <= 60'(tm[k][l][50:26]) * 60'(upd.x2);
        sc2  <= prod[85:28];
        pp0  <= 58'(sc2[28:0])  * 58'(RCP[28:0]);
        pp1  <= 58'(sc2[28:0])  * 58'(RCP[57:29]);
        pp2  <= 58'(sc2[57:29]) * 58'(RCP[28:0]);
        pp3  <= 58'(sc2[57:29]) * 58'(RCP[57:29]);
        sc3  <= sc2;
        q4   <= full[114:58];
        sc4  <= sc3;
        mag5 <= (q5 > 58'(TERM_CAP)) ? TERM_CAP : q5[MAG_W-1:0];
      end

      assign tm[k+1][l] = mag5;
    end
  end

  // ---------------- output ----------------
  function automatic logic [OUT_W-1:0] sat32(input logic [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = $signed(v);
    if (s > $signed(SUM_W'(32'h7FFF_FFFF))) begin
      return 32'h7FFF_FFFF;
    end else if (s < -$signed(SUM_W'(33'h0_8000_0000))) begin
      return 32'h8000_0000;
    end else begin
      return v[OUT_W-1:0];
    end
  endfunction

  ctl_t             fin;
  logic [1:0]       hit_limit;

  assign fin          = tc[MAX_TERMS];
  assign hit_limit[0] = !fin.done[0] && !(tm[MAX_TERMS][0] < MAG_W'(thr));
  assign hit_limit[1] = !fin.done[1] && !(tm[MAX_TERMS][1] < MAG_W'(thr));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    sine          <= $signed(sat32(fin.sum[0]));
    cosine        <= $signed(sat32(fin.sum[1]));
    not_converged <= |hit_limit;
  end

  // ---------------- checks ----------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start && !busy, LATENCY))
    else $error("result without a transaction accepted LATENCY cycles earlier");

  a_fin_vld: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(fin.vld))
    else $error("result strobe not fed by last term stage");

  a_cap: assert property (@(posedge clk) disable iff (rst)
    fin.vld |-> (tm[MAX_TERMS][0] <= TERM_CAP) && (tm[MAX_TERMS][1] <= TERM_CAP))
    else $error("term magnitude above cap");

endmodule

### bench/tb_taylor_sine_cosine.sv
// Testbench for taylor_sine_cosine: directed table plus random angles, checked against a predictor.
module tb_taylor_sine_cosine;
  import tsc_pkg::*;

  localparam int LATENCY = 166;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ANG_W-1:0] angle_deg = '0;
  logic stop_threshold_wr = 1'b0;
  logic [THR_W-1:0] stop_threshold = '0;
  logic valid;
  logic signed [OUT_W-1:0] sine, cosine;
  logic not_converged;

  typedef struct packed {
    logic [OUT_W-1:0] sin_q30;
    logic [OUT_W-1:0] cos_q30;
    logic             flag;
  } trig_t;

  typedef struct {
    logic signed [ANG_W-1:0] ang;
    bit    known;
    trig_t want;
  } row_t;

  trig_t pending_trig[$];
  logic [THR_W-1:0] thr_model;
  bit failed = 0;
  int sender_idle_pct = 0;

  taylor_sine_cosine DUT (
    .clk, .rst, .start, .busy, .angle_deg, .stop_threshold_wr, .stop_threshold,
    .valid, .sine, .cosine, .not_converged
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #200000000;
    $display("Simulation FAILED");
    $finish;
  end

  // One series: sign-magnitude terms, stop below threshold or at MAX_TERMS.
  function automatic logic signed [63:0] sum_series(bit neg, logic [63:0] mag,
      logic [63:0] x2, int off, ref bit flag);
    logic signed [63:0] acc;
    logic [127:0] prod;
    logic [63:0] scaled, d;
    acc = 0;
    for (int k = 0; ; k++) begin
      if (mag < {33'd0, thr_model}) break;
      if (k >= MAX_TERMS) begin
        flag = 1;
        break;
      end
      acc += neg ? -$signed(mag) : $signed(mag);
      prod = mag * x2;
      scaled = (prod[127:92] != 0) ? 64'(TERM_CAP) : prod[91:28];
      d = (2 * k + 1 + off) * (2 * k + 2 + off);
      mag = scaled / d;
      if (mag > 64'(TERM_CAP)) mag = 64'(TERM_CAP);
      neg = !neg;
    end
    return acc;
  endfunction

  function automatic logic [OUT_W-1:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFFFFFF;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic trig_t predict_trig(logic signed [ANG_W-1:0] ang);
    logic [63:0] amag, xm, x2;
    bit flag;
    trig_t r;
    logic signed [63:0] s, c;
    amag = ang < 0 ? 64'(-ang) : 64'(ang);
    xm = (amag * 64'd31415926 * 64'd1048576 + 64'd900000000) / 64'd1800000000;
    x2 = (xm * xm) >> 28;
    flag = 0;
    s = sum_series(ang < 0, xm << 2, x2, 1, flag);
    c = sum_series(0, 64'd1 << 30, x2, 0, flag);
    r.sin_q30 = clamp32(s);
    r.cos_q30 = clamp32(c);
    r.flag = flag;
    return r;
  endfunction

  always @(posedge clk) begin
    trig_t e;
    if (!rst && valid) begin
      if (pending_trig.size() == 0) begin
        $error("result with no transaction pending");
        failed = 1;
      end else begin
        e = pending_trig.pop_front();
        if (sine !== e.sin_q30) begin
          $error("sine: expected %h actual %h", e.sin_q30, sine);
          failed = 1;
        end
        if (cosine !== e.cos_q30) begin
          $error("cosine: expected %h actual %h", e.cos_q30, cosine);
          failed = 1;
        end
        if (not_converged !== e.flag) begin
          $error("not_converged: expected %b actual %b", e.flag, not_converged);
          failed = 1;
        end
      end
    end
  end

  // start stays high between back-to-back transactions; idle cycles drop it.
  task automatic send_angle(logic signed [ANG_W-1:0] ang, bit known, trig_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    angle_deg <= ang;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_trig.push_back(known ? want : predict_trig(ang));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_trig.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    stop_threshold_wr <= 1'b1;
    stop_threshold <= v;
    @(negedge clk);
    stop_threshold_wr <= 1'b0;
    thr_model = v;
  endtask

  // Random angle: mostly within +/-360 degrees, some anywhere in the 18-bit range.
  function automatic logic signed [ANG_W-1:0] rand_angle();
    case ($urandom_range(9))
      0: return ANG_W'($urandom);
      1: return ANG_W'($signed($urandom_range(2048)) - 1024);
      default: return ANG_W'($signed($urandom_range(184320)) - 92160);
    endcase
  endfunction

  row_t dir_rows[] = '{
    '{18'sd0,      1, '{32'd0, 32'h40000000, 1'b0}},
    '{18'sd23040,  0, '0},   // 90 deg
    '{-18'sd23040, 0, '0},
    '{18'sd46080,  0, '0},   // 180 deg
    '{18'sd92160,  0, '0},   // 360 deg
    '{-18'sd92160, 0, '0},
    '{18'sd1,      0, '0},
    '{-18'sd1,     0, '0},
    '{18'sd131071, 0, '0},   // beyond 360, max positive
    '{-18'sd131072,0, '0},   // most negative
    '{18'sd11520,  0, '0},
    '{18'sd69120,  0, '0},
    '{18'h2AAAA,   0, '0},
    '{18'h15555,   0, '0}
  };

  logic [THR_W-1:0] thr_set[] = '{31'd1, 31'd1073741824, 31'd0, 31'h7FFFFFFF,
                                  31'd65536, 31'd1074};

  initial begin
    trig_t none;
    none = '0;
    thr_model = THR_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_angle(dir_rows[i].ang, dir_rows[i].known, dir_rows[i].want);
    drain_pipe();

    // Each threshold, including zero (only the term limit stops), across idle modes.
    foreach (thr_set[t]) begin
      write_threshold(thr_set[t]);
      send_angle(18'sd0, 0, none);
      send_angle(-18'sd92160, 0, none);
      for (int i = 0; i < 60; i++) begin
        sender_idle_pct = (i < 20) ? 29 : (i < 40) ? 82 : 0;
        send_angle(rand_angle(), 0, none);
      end
      drain_pipe();
    end

    write_threshold(THR_W'($urandom_range(4096, 1)));
    for (int i = 0; i < 1500; i++) begin
      sender_idle_pct = (i < 500) ? 29 : (i < 1000) ? 82 : 0;
      send_angle(rand_angle(), 0, none);
    end
    drain_pipe();

    if (!failed) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
